/* sv/mse_pkg.sv */
// mse_pkg: shared constants, opcodes and transfer structs for the MIPS subset execute unit.
// No dependencies; imported by the top level, mse_dmem and mse_outq.
package mse_pkg;

    localparam int unsigned MEM_BYTES_DEF = 1024;
    localparam int unsigned NREGS         = 32;
    localparam int unsigned OUTQ_DEPTH    = 4;

    // opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-type function codes
    localparam logic [5:0] FN_JR  = 6'h08;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_XOR = 6'h26;
    localparam logic [5:0] FN_NOR = 6'h27;
    localparam logic [5:0] FN_SLT = 6'h2A;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [31:0] PC_STEP        = 32'd4;
    localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

    // data memory request, issued from the execute stage
    typedef struct packed {
        logic        wr;
        logic [31:0] addr;
        logic [31:0] wdata;
    } mse_dreq_t;

    // one result transfer
    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  status;
        logic        wen;
        logic [4:0]  wreg;
        logic [31:0] wval;
    } mse_res_t;

endpackage

/* sv/mips_subset_execute_unit.sv */
// mips_subset_execute_unit: top level, register file, execute and memory stages, clear sequencer.
// Depends on mse_pkg, mse_ram, mse_dmem and mse_outq.
//
// Usage:
//  - instruction channel (instr_valid / instr_stall / instruction): one 32-bit word per transfer.
//  - result channel (res_valid / res_stall / next_pc, status, write_enable, write_register,
//    write_value): exactly one result transfer per instruction, in order.
//  - Path: an instruction passes through the execute stage, then the memory/write-back stage,
//    then the result queue, before its result shows on the ports.
//  - Throughput: one instruction per cycle while instr_stall is low. Dependent instructions
//    do not wait: register values are forwarded from the write-back stage and from the previous
//    cycle's write, since the two register file copies are read as the instruction is taken.
//  - Reset: registers, data memory and PC go to zero. The register file and data memory
//    RAMs are zeroed by a clearing pass that walks the register addresses and memory rows
//    (one row of all four byte banks per cycle); instr_stall stays high until it ends.
//  - Receiver stall: results collect in a 4-entry queue. Instructions keep being taken
//    while queue entries plus instructions in flight stay below 4; then instr_stall rises.
//  - An invalid opcode reports status 2 and keeps the PC, so the program stops there.
module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_stall,
    input  logic [31:0]        instruction,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [31:0]        next_pc,
    output logic [1:0]         status,
    output logic               write_enable,
    output logic [4:0]         write_register,
    output logic signed [31:0] write_value
);

    localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CLR_N = (ROWS > NREGS) ? ROWS : NREGS;
    localparam int unsigned CLR_W = $clog2(CLR_N + 1);
    localparam int unsigned CW    = $clog2(OUTQ_DEPTH + 1);
    localparam int unsigned OCC_W = $clog2(OUTQ_DEPTH + 3);

    // ---------------- clearing pass after reset ----------------
    logic             clear_active_reg, clear_active_next;
    logic [CLR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic             clear_rf;
    logic             clear_mem;

    assign clear_rf  = clear_active_reg && (clear_cnt_reg < CLR_W'(NREGS));
    assign clear_mem = clear_active_reg && (clear_cnt_reg < CLR_W'(ROWS));

    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_cnt_next    = clear_cnt_reg;
        if (clear_active_reg)
        begin
            if (clear_cnt_reg == CLR_W'(CLR_N - 1))
            begin
                clear_active_next = 1'b0;
            end
            else
            begin
                clear_cnt_next = clear_cnt_reg + CLR_W'(1);
            end
        end
    end

    // ---------------- intake control ----------------
    logic [CW-1:0]    q_count;
    logic [OCC_W-1:0] occ;
    logic             accept;
    logic             e_valid_reg;
    logic             m_valid_reg;

    assign occ         = OCC_W'(q_count) + OCC_W'(e_valid_reg) + OCC_W'(m_valid_reg);
    assign instr_stall = clear_active_reg || (occ >= OCC_W'(OUTQ_DEPTH));
    assign accept      = instr_valid && !instr_stall;

    // ---------------- register file: two copies for two read ports ----------------
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [31:0] rf_a_q;
    logic [31:0] rf_b_q;

    mse_ram #(
        .WIDTH (32),
        .DEPTH (NREGS)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (instruction[25:21]),
        .rdata (rf_a_q)
    );

    mse_ram #(
        .WIDTH (32),
        .DEPTH (NREGS)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (instruction[20:16]),
        .rdata (rf_b_q)
    );

    // ---------------- execute stage ----------------
    logic [31:0] e_instr_reg;
    logic [31:0] pc_reg, pc_next;
    logic [5:0]  e_op;
    logic [5:0]  e_fn;
    logic [4:0]  e_rs;
    logic [4:0]  e_rt;
    logic [4:0]  e_rd;
    logic [31:0] e_imm;
    logic [31:0] e_a;
    logic [31:0] e_b;
    logic [31:0] e_npc;
    logic [1:0]  e_status;
    logic        e_wen;
    logic [4:0]  e_wreg;
    logic [31:0] e_alu;
    logic        e_load;
    mse_dreq_t   dreq;

    // memory/write-back stage and last-write registers (used for forwarding)
    logic [31:0] m_pc_reg;
    logic [1:0]  m_status_reg;
    logic        m_wen_reg;
    logic [4:0]  m_wreg_reg;
    logic [31:0] m_alu_reg;
    logic        m_load_reg;
    logic [31:0] m_wval;
    logic [31:0] dmem_rdata;
    logic        w_valid_reg;
    logic [4:0]  w_reg_reg;
    logic [31:0] w_val_reg;

    assign e_op  = e_instr_reg[31:26];
    assign e_rs  = e_instr_reg[25:21];
    assign e_rt  = e_instr_reg[20:16];
    assign e_rd  = e_instr_reg[15:11];
    assign e_fn  = e_instr_reg[5:0];
    assign e_imm = {{16{e_instr_reg[15]}}, e_instr_reg[15:0]};

    assign m_wval = m_load_reg ? dmem_rdata : m_alu_reg;

    // register zero reads as zero, else newest value wins: write-back stage, last cycle's write, RAM
    function automatic logic [31:0] fwd_pick(
        input logic [4:0]  idx,
        input logic [31:0] ram_q,
        input logic        m_hit_ok,
        input logic [4:0]  m_idx,
        input logic [31:0] m_val,
        input logic        w_hit_ok,
        input logic [4:0]  w_idx,
        input logic [31:0] w_val
    );
        logic [31:0] v;
        if (idx == 5'd0)
        begin
            v = '0;
        end
        else if (m_hit_ok && (m_idx == idx))
        begin
            v = m_val;
        end
        else if (w_hit_ok && (w_idx == idx))
        begin
            v = w_val;
        end
        else
        begin
            v = ram_q;
        end
        return v;
    endfunction

    assign e_a = fwd_pick(e_rs, rf_a_q, m_valid_reg && m_wen_reg, m_wreg_reg, m_wval,
                          w_valid_reg, w_reg_reg, w_val_reg);
    assign e_b = fwd_pick(e_rt, rf_b_q, m_valid_reg && m_wen_reg, m_wreg_reg, m_wval,
                          w_valid_reg, w_reg_reg, w_val_reg);

    always_comb
    begin
        logic        rw;
        logic [31:0] rv;
        rw         = 1'b0;
        rv         = '0;
        e_npc      = pc_reg + PC_STEP;
        e_status   = ST_OK;
        e_wen      = 1'b0;
        e_wreg     = '0;
        e_alu      = '0;
        e_load     = 1'b0;
        dreq.wr    = 1'b0;
        dreq.addr  = e_a + e_imm;
        dreq.wdata = e_b;
        unique case (e_op) inside
            OP_RTYPE:
            begin
                unique case (e_fn)
                    FN_ADD: begin rw = 1'b1; rv = e_a + e_b; end
                    FN_SUB: begin rw = 1'b1; rv = e_a - e_b; end
                    FN_OR:  begin rw = 1'b1; rv = e_a | e_b; end
                    FN_XOR: begin rw = 1'b1; rv = e_a ^ e_b; end
                    FN_NOR: begin rw = 1'b1; rv = ~(e_a | e_b); end
                    FN_SLT:
                    begin
                        rw = 1'b1;
                        rv = {31'd0, ($signed(e_a) < $signed(e_b))};
                    end
                    FN_JR:  e_npc = e_a;
                    default: ;  // unknown function: no effect
                endcase
                if (rw && (e_rd != 5'd0))
                begin
                    e_wen  = 1'b1;
                    e_wreg = e_rd;
                    e_alu  = rv;
                end
            end
            OP_J:
            begin
                e_npc = (pc_reg & PC_REGION_MASK) | {4'd0, e_instr_reg[25:0], 2'd0};
            end
            OP_LW, OP_SW:
            begin
                // all four bytes must lie inside the memory
                if (dreq.addr > 32'(MEM_BYTES - 4))
                begin
                    e_status = ST_RANGE;
                end
                else if (e_op == OP_LW)
                begin
                    if (e_rt != 5'd0)
                    begin
                        e_wen  = 1'b1;
                        e_wreg = e_rt;
                        e_load = 1'b1;
                    end
                end
                else
                begin
                    dreq.wr = e_valid_reg;
                end
            end
            default:
            begin
                e_status = ST_INVALID;
                e_npc    = pc_reg;
            end
        endcase
    end

    assign pc_next = e_valid_reg ? e_npc : pc_reg;

    // ---------------- data memory ----------------
    mse_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .clk     (clk),
        .req     (dreq),
        .clr_en  (clear_mem),
        .clr_row (ROW_W'(clear_cnt_reg)),
        .rdata   (dmem_rdata)
    );

    // ---------------- write-back ----------------
    assign rf_we    = clear_rf || (m_valid_reg && m_wen_reg);
    assign rf_waddr = clear_rf ? clear_cnt_reg[4:0] : m_wreg_reg;
    assign rf_wdata = clear_rf ? 32'd0 : m_wval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
            e_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            w_valid_reg      <= 1'b0;
            pc_reg           <= '0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_cnt_reg    <= clear_cnt_next;
            e_valid_reg      <= accept;
            m_valid_reg      <= e_valid_reg;
            w_valid_reg      <= m_valid_reg && m_wen_reg;
            pc_reg           <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_instr_reg <= instruction;
        end
        m_pc_reg     <= e_npc;
        m_status_reg <= e_status;
        m_wen_reg    <= e_wen;
        m_wreg_reg   <= e_wreg;
        m_alu_reg    <= e_alu;
        m_load_reg   <= e_load;
        w_reg_reg    <= m_wreg_reg;
        w_val_reg    <= m_wval;
    end

    // ---------------- result queue ----------------
    mse_res_t m_res;
    mse_res_t q_head;

    assign m_res.next_pc = m_pc_reg;
    assign m_res.status  = m_status_reg;
    assign m_res.wen     = m_wen_reg;
    assign m_res.wreg    = m_wreg_reg;
    assign m_res.wval    = m_wval;

    mse_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (m_valid_reg),
        .push_data (m_res),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .head      (q_head),
        .count     (q_count)
    );

    assign next_pc        = q_head.next_pc;
    assign status         = q_head.status;
    assign write_enable   = q_head.wen;
    assign write_register = q_head.wreg;
    assign write_value    = $signed(q_head.wval);

`ifndef SYNTHESIS
    // no instruction enters while the RAMs are being zeroed
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> instr_stall)
        else $error("instruction taken during clearing pass");

    // queue plus in-flight work never exceeds the queue size
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OCC_W'(OUTQ_DEPTH))
        else $error("result queue credit overrun");

    // register zero is never written outside the clearing pass
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rf_we && !clear_active_reg) |-> (rf_waddr != 5'd0))
        else $error("write to register zero");

    // an invalid opcode leaves the PC where it was
    a_invalid_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && (e_status == ST_INVALID)) |=> (pc_reg == $past(pc_reg)))
        else $error("PC moved on invalid opcode");

    // a load with its load flag set in write-back always writes a register
    a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_load_reg) |-> m_wen_reg)
        else $error("load without register write");
`endif

endmodule

/* sv/mse_ram.sv */
// mse_ram: generic single-write, single-read synchronous RAM, registered read (read-first).
// No dependencies.
module mse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/mse_dmem.sv */
// mse_dmem: byte-addressed little-endian data memory as four byte banks, unaligned word access.
// Depends on mse_pkg and mse_ram.
module mse_dmem
    import mse_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
    localparam int unsigned ROWS     = (MEM_BYTES + 3) / 4,
    localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             clk,
    input  mse_dreq_t        req,
    input  logic             clr_en,
    input  logic [ROW_W-1:0] clr_row,
    output logic [31:0]      rdata
);

    logic [1:0]       lo;
    logic [ROW_W-1:0] base_row;
    logic [1:0]       lo_reg;
    logic [7:0]       bank_q [4];

    assign lo       = req.addr[1:0];
    assign base_row = req.addr[ROW_W+1:2];

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [1:0]       byte_sel;
        logic [ROW_W-1:0] row;
        logic [7:0]       wbyte;

        // bank k holds byte (k - lo) of the word; wraps into the next row when k < lo
        assign byte_sel = 2'(k) - lo;
        assign row      = base_row + ROW_W'(2'(k) < lo);
        assign wbyte    = req.wdata[8*byte_sel +: 8];

        mse_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (clr_en | req.wr),
            .waddr (clr_en ? clr_row : row),
            .wdata (clr_en ? 8'd0 : wbyte),
            .raddr (row),
            .rdata (bank_q[k])
        );
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo;
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rdata[8*j +: 8] = bank_q[lo_reg + 2'(j)];
        end
    end

endmodule

/* sv/mse_outq.sv */
// mse_outq: small result queue that parts the pipeline from the result channel.
// Depends on mse_pkg.
module mse_outq
    import mse_pkg::*;
#(
    localparam int unsigned PW = $clog2(OUTQ_DEPTH),
    localparam int unsigned CW = $clog2(OUTQ_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mse_res_t      push_data,
    input  logic          res_stall,
    output logic          res_valid,
    output mse_res_t      head,
    output logic [CW-1:0] count
);

    mse_res_t      slot_reg [OUTQ_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign res_valid = (count_reg != '0);
    assign pop       = res_valid && !res_stall;
    assign head      = slot_reg[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next  = pop ? head_reg + PW'(1) : head_reg;
        tail_next  = push ? tail_reg + PW'(1) : tail_reg;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule
